/* rtl/string_to_integer_parser_assert.svh */
// Assertion macros shared by the parser RTL.
// Users supply the clock and reset by the names i_clk and i_rst_n.
`ifndef STRING_TO_INTEGER_PARSER_ASSERT_SVH
`define STRING_TO_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define STP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define STP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/stp_pkg.sv */
// Shared types, character codes and digit decoding for the string parser.
// No dependencies; referenced by the input channel interface and imported by the top level.
package stp_pkg;

    typedef logic [7:0] t_char;
    typedef logic [5:0] t_base;

    typedef struct packed {
        logic  ok;
        t_base val;
    } t_digit;

    localparam t_char CH_NUL   = 8'h00;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_MINUS = 8'h2D;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_NINE  = 8'h39;
    localparam t_char CH_UA    = 8'h41;
    localparam t_char CH_UZ    = 8'h5A;
    localparam t_char CH_LA    = 8'h61;
    localparam t_char CH_X     = 8'h78;
    localparam t_char CH_LZ    = 8'h7A;

    localparam t_base BASE_DETECT = 6'd0;
    localparam t_base BASE_OCT    = 6'd8;
    localparam t_base BASE_DEC    = 6'd10;
    localparam t_base BASE_HEX    = 6'd16;

    // Digit value of a character: 0-9, then letters of either case as 10..35
    function automatic t_digit digit_of(input t_char c);
        t_digit d;
        t_char  t;
        d = '0;
        t = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
            d.ok = 1'b1;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            t = c - CH_LA + 8'd10;
            d.ok = 1'b1;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            t = c - CH_UA + 8'd10;
            d.ok = 1'b1;
        end
        d.val = t[5:0];
        return d;
    endfunction

endpackage

/* rtl/stp_in_if.sv */
// Input character channel: valid/ready handshake, one byte per beat.
// Depends on stp_pkg for the character type.
interface stp_in_if;
    logic           valid;
    logic           ready;
    stp_pkg::t_char ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

/* rtl/stp_out_if.sv */
// Result channel: valid/ready handshake carrying parsed value and end offset.
// Widths follow the parser's VALUE_WIDTH and OFFSET_WIDTH.
interface stp_out_if #(
    parameter int VALUE_WIDTH  = 32,
    parameter int OFFSET_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [OFFSET_WIDTH-1:0]       end_offset;

    modport source (output valid, output value, output end_offset, input ready);
    modport sink   (input valid, input value, input end_offset, output ready);
endinterface

/* rtl/string_to_integer_parser.sv */
// Streaming integer parser: one string byte per beat, one result per string.
// Latency: a result is valid the cycle after the byte that ends the number.
// Throughput: one byte per cycle; the input is held off only while a result
// sits in the output register and the sink is not ready.
// Reset (synchronous, active low): parser idle at string start, base register 0.
// Depends on stp_pkg, stp_in_if, stp_out_if and the assertion macro header.
`include "string_to_integer_parser_assert.svh"

module string_to_integer_parser #(
    parameter int VALUE_WIDTH  = 32,
    parameter int OFFSET_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  stp_pkg::t_base    i_cfg_data,
    output logic              o_cfg_ready,
    stp_in_if.sink            i_in,
    stp_out_if.source         o_out
);
    import stp_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DRAIN
    } t_phase;

    // Architectural state
    t_phase                  r_phase,   n_phase;
    logic                    r_neg,     n_neg;
    logic [VALUE_WIDTH-1:0]  r_acc,     n_acc;
    t_base                   r_abase,   n_abase;
    logic [OFFSET_WIDTH-1:0] r_cnt,     n_cnt;
    t_base                   r_cfg_base;

    // Result register
    logic                          r_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_out_value;
    logic [OFFSET_WIDTH-1:0]       r_out_offset;

    logic                    in_fire, out_fire;
    t_digit                  dig;
    t_base                   use_base;
    logic                    take, hit, inc, clr, emit;
    logic [VALUE_WIDTH-1:0]  prod;
    logic [VALUE_WIDTH-1:0]  res_value;

    assign o_cfg_ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_fire    = r_out_valid && o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.value      = r_out_value;
    assign o_out.end_offset = r_out_offset;

    assign dig  = digit_of(i_in.ch);
    assign hit  = dig.ok && (dig.val < use_base);
    // Multiply-add by the radix, wrapping at the value width
    assign prod = VALUE_WIDTH'(r_acc * VALUE_WIDTH'(use_base)) + VALUE_WIDTH'(dig.val);
    assign res_value = r_neg ? (VALUE_WIDTH'(0) - r_acc) : r_acc;

    // Next-state decode for one accepted byte
    always_comb begin
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_abase  = r_abase;
        n_cnt    = r_cnt;
        use_base = r_abase;
        take     = 1'b0;
        inc      = 1'b0;
        clr      = 1'b0;
        emit     = 1'b0;

        unique case (r_phase)
            PH_LEAD, PH_SIGNED: begin
                if (r_phase == PH_LEAD && (i_in.ch == CH_SPACE || i_in.ch == CH_TAB)) begin
                    inc = 1'b1;
                end else if (r_phase == PH_LEAD &&
                             (i_in.ch == CH_PLUS || i_in.ch == CH_MINUS)) begin
                    n_neg   = (i_in.ch == CH_MINUS);
                    inc     = 1'b1;
                    n_phase = PH_SIGNED;
                end else if (i_in.ch == CH_ZERO &&
                             (r_cfg_base == BASE_DETECT || r_cfg_base == BASE_HEX)) begin
                    n_abase = r_cfg_base;
                    inc     = 1'b1;
                    n_phase = PH_ZERO;
                end else begin
                    use_base = (r_cfg_base == BASE_DETECT) ? BASE_DEC : r_cfg_base;
                    take     = 1'b1;
                end
            end
            PH_ZERO: begin
                if (i_in.ch == CH_X) begin
                    n_abase = BASE_HEX;
                    inc     = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    use_base = (r_abase == BASE_DETECT) ? BASE_OCT : r_abase;
                    take     = 1'b1;
                end
            end
            PH_DIGITS: begin
                take = 1'b1;
            end
            PH_DRAIN: begin
                clr = (i_in.ch == CH_NUL);
            end
            default: begin
                clr = 1'b1;
            end
        endcase

        // Shared digit step: accumulate or close the number
        if (take) begin
            n_abase = use_base;
            n_phase = PH_DIGITS;
            if (hit) begin
                n_acc = prod;
                inc   = 1'b1;
            end else begin
                emit    = 1'b1;
                clr     = (i_in.ch == CH_NUL);
                n_phase = PH_DRAIN;
            end
        end

        if (inc && r_cnt != '1) begin
            n_cnt = r_cnt + 1'b1;
        end

        if (clr) begin
            n_phase = PH_LEAD;
            n_neg   = 1'b0;
            n_acc   = '0;
            n_abase = BASE_DETECT;
            n_cnt   = '0;
        end
    end

    // State, config and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_abase     <= BASE_DETECT;
            r_cnt       <= '0;
            r_cfg_base  <= BASE_DETECT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg_base <= i_cfg_data;
            end
            if (in_fire) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
                r_abase <= n_abase;
                r_cnt   <= n_cnt;
            end
            if (in_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_fire && emit) begin
            r_out_value  <= res_value;
            r_out_offset <= r_cnt;
        end
    end

    // Checks
    `STP_ASSERT_NOW(a_ready_when_empty, !r_out_valid, i_in.ready,
        "input stalled with empty result register")
    `STP_ASSERT_NEXT(a_nul_restarts, in_fire && i_in.ch == CH_NUL,
        r_phase == PH_LEAD && r_cnt == '0 && r_acc == '0,
        "string terminator did not restart the parser")
    `STP_ASSERT_NEXT(a_no_spurious_result, (!r_out_valid || out_fire) && !in_fire,
        !r_out_valid, "result appeared without an accepted byte")
    `STP_ASSERT_NOW(a_digits_base_set, r_phase == PH_DIGITS, r_abase != BASE_DETECT,
        "digit phase entered without a radix")
    `STP_ASSERT_NOW(a_zero_prefix_base, r_phase == PH_ZERO,
        r_abase == BASE_DETECT || r_abase == BASE_HEX,
        "prefix phase holds an unexpected radix")

endmodule
